// ----- rtl/ps2_mouse_packet_accumulator_defines.svh -----
// Assertion macros shared by the verification side of the PS/2 mouse packet accumulator.
// No dependencies; each macro expects clk and rst_n in scope where it is used.
`ifndef PS2_MOUSE_PACKET_ACCUMULATOR_DEFINES_SVH
`define PS2_MOUSE_PACKET_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PS2MA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PS2MA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ps2ma_pkg.sv -----
// Package for the PS/2 mouse packet accumulator: transfer types, event codes
// and header bit positions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ps2ma_pkg;

    localparam int unsigned TotalW = 16;

    typedef struct packed {
        logic       cmd;
        logic       data_ready;
        logic       from_aux;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]               event_code;
        logic signed [TotalW-1:0] total_dx;
        logic signed [TotalW-1:0] total_dy;
        logic [2:0]               buttons;
    } rsp_t;

    localparam logic [2:0] EvStored   = 3'd0;
    localparam logic [2:0] EvApplied  = 3'd1;
    localparam logic [2:0] EvOverflow = 3'd2;
    localparam logic [2:0] EvNoData   = 3'd3;
    localparam logic [2:0] EvNotAux   = 3'd4;
    localparam logic [2:0] EvResync   = 3'd5;
    localparam logic [2:0] EvConsumed = 3'd6;

    // Header byte layout.
    localparam int unsigned HdrBtnLo   = 0;
    localparam int unsigned HdrBtnHi   = 2;
    localparam int unsigned HdrSyncBit = 3;
    localparam int unsigned HdrXSign   = 4;
    localparam int unsigned HdrYSign   = 5;
    localparam int unsigned HdrXOvf    = 6;
    localparam int unsigned HdrYOvf    = 7;

    localparam logic [1:0] PosHeader = 2'd0;
    localparam logic [1:0] PosX      = 2'd1;
    localparam logic [1:0] PosY      = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/ps2_mouse_packet_accumulator.sv -----
// Every request (a controller byte or a consume command) produces exactly one response, in
// order. A request is registered on entry and its response is then registered in the
// response register, and one request can be taken every cycle; the only limit is the
// response side's stall, which backs up through the two registers. Three aux bytes form a
// packet: the header sets button levels, and unless an overflow bit is set the sign-extended
// X and negated Y motion is added to saturating ACC_WIDTH-bit totals. A consume returns the
// totals and clears them. Responses carry the totals, sign-extended or cut to 16 bits.
// Depends on ps2ma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_accumulator #(
    parameter int unsigned ACC_WIDTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ps2ma_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ps2ma_pkg::rsp_t     rsp
);

    localparam int unsigned SumW = ACC_WIDTH + 1;
    localparam int unsigned ExtW = (ACC_WIDTH > ps2ma_pkg::TotalW) ? ACC_WIDTH
                                                                   : ps2ma_pkg::TotalW;
    localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // Entry register and response register.
    logic            s1_valid_reg;
    ps2ma_pkg::req_t s1_reg;
    logic            rsp_valid_reg;
    ps2ma_pkg::rsp_t rsp_reg;
    ps2ma_pkg::rsp_t rsp_next;

    // Packet and accumulator state.
    logic [1:0]                  pos_reg, pos_next;
    logic [7:0]                  hdr_reg, hdr_next;
    logic [7:0]                  xb_reg, xb_next;
    logic signed [ACC_WIDTH-1:0] sum_x_reg, sum_x_next;
    logic signed [ACC_WIDTH-1:0] sum_y_reg, sum_y_next;
    logic [2:0]                  btn_reg, btn_next;

    logic rsp_adv;
    logic s1_adv;
    logic s1_move;

    logic signed [9:0]           dx;
    logic signed [9:0]           dy_raw;
    logic signed [9:0]           dy;
    logic signed [SumW-1:0]      wide_x;
    logic signed [SumW-1:0]      wide_y;
    logic signed [ACC_WIDTH-1:0] sat_x;
    logic signed [ACC_WIDTH-1:0] sat_y;
    logic signed [ACC_WIDTH-1:0] rep_x;
    logic signed [ACC_WIDTH-1:0] rep_y;
    logic signed [ExtW-1:0]      ext_x;
    logic signed [ExtW-1:0]      ext_y;
    logic [2:0]                  code;

    assign rsp_adv   = !rsp_valid_reg || !rsp_stall;
    assign s1_adv    = !s1_valid_reg || rsp_adv;
    assign s1_move   = s1_valid_reg && rsp_adv;
    assign req_stall = !s1_adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Packet motion, with Y negated so that positive means down.
    assign dx     = {{2{hdr_reg[ps2ma_pkg::HdrXSign]}}, xb_reg};
    assign dy_raw = {{2{hdr_reg[ps2ma_pkg::HdrYSign]}}, s1_reg.rx_byte};
    assign dy     = -dy_raw;

    assign wide_x = SumW'(sum_x_reg) + SumW'(dx);
    assign wide_y = SumW'(sum_y_reg) + SumW'(dy);

    // The sum overflowed when its two top bits disagree; the top bit gives the direction.
    assign sat_x = (wide_x[SumW-1] != wide_x[SumW-2]) ? (wide_x[SumW-1] ? AccMin : AccMax)
                                                      : wide_x[ACC_WIDTH-1:0];
    assign sat_y = (wide_y[SumW-1] != wide_y[SumW-2]) ? (wide_y[SumW-1] ? AccMin : AccMax)
                                                      : wide_y[ACC_WIDTH-1:0];

    always_comb
    begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        xb_next    = xb_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        btn_next   = btn_reg;
        code       = ps2ma_pkg::EvNoData;
        if (s1_reg.cmd)
        begin
            code       = ps2ma_pkg::EvConsumed;
            sum_x_next = '0;
            sum_y_next = '0;
        end
        else if (!s1_reg.data_ready)
        begin
            code = ps2ma_pkg::EvNoData;
        end
        else if (!s1_reg.from_aux)
        begin
            code = ps2ma_pkg::EvNotAux;
        end
        else
        begin
            case (pos_reg)
                ps2ma_pkg::PosHeader:
                begin
                    if (!s1_reg.rx_byte[ps2ma_pkg::HdrSyncBit])
                    begin
                        code = ps2ma_pkg::EvResync;
                    end
                    else
                    begin
                        hdr_next = s1_reg.rx_byte;
                        pos_next = ps2ma_pkg::PosX;
                        code     = ps2ma_pkg::EvStored;
                    end
                end
                ps2ma_pkg::PosX:
                begin
                    xb_next  = s1_reg.rx_byte;
                    pos_next = ps2ma_pkg::PosY;
                    code     = ps2ma_pkg::EvStored;
                end
                default:
                begin
                    // Third byte; an out-of-range position is treated the same way.
                    btn_next = hdr_reg[ps2ma_pkg::HdrBtnHi:ps2ma_pkg::HdrBtnLo];
                    pos_next = ps2ma_pkg::PosHeader;
                    if (hdr_reg[ps2ma_pkg::HdrXOvf] || hdr_reg[ps2ma_pkg::HdrYOvf])
                    begin
                        code = ps2ma_pkg::EvOverflow;
                    end
                    else
                    begin
                        sum_x_next = sat_x;
                        sum_y_next = sat_y;
                        code       = ps2ma_pkg::EvApplied;
                    end
                end
            endcase
        end
    end

    // A consume reports the totals from before the clear.
    assign rep_x = s1_reg.cmd ? sum_x_reg : sum_x_next;
    assign rep_y = s1_reg.cmd ? sum_y_reg : sum_y_next;
    assign ext_x = ExtW'(rep_x);
    assign ext_y = ExtW'(rep_y);

    always_comb
    begin
        rsp_next.event_code = code;
        rsp_next.total_dx   = ext_x[ps2ma_pkg::TotalW-1:0];
        rsp_next.total_dy   = ext_y[ps2ma_pkg::TotalW-1:0];
        rsp_next.buttons    = btn_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pos_reg       <= ps2ma_pkg::PosHeader;
            hdr_reg       <= '0;
            xb_reg        <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            btn_reg       <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= req_valid;
            end
            if (rsp_adv)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                pos_reg   <= pos_next;
                hdr_reg   <= hdr_next;
                xb_reg    <= xb_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                btn_reg   <= btn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && req_valid)
        begin
            s1_reg <= req;
        end
        if (s1_move)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ps2ma_checker.sv -----
// Port-level checker for the PS/2 mouse packet accumulator, bound to the top level.
// Depends on ps2ma_pkg and ps2_mouse_packet_accumulator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_packet_accumulator_defines.svh"

module ps2ma_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            rsp_valid,
    input wire logic            rsp_stall,
    input wire ps2ma_pkg::rsp_t rsp
);

    // Totals and buttons from the last response transfer; all zero out of reset.
    logic        rsp_xfer;
    logic        last_consumed_reg;
    logic [15:0] last_dx_reg;
    logic [15:0] last_dy_reg;
    logic [2:0]  last_btn_reg;
    logic        totals_kept;
    logic        buttons_kept;
    logic        rsp_held;
    logic        clear_due;
    logic        totals_zero;
    logic        totals_same;
    logic        buttons_same;

    assign rsp_xfer = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_consumed_reg <= 1'b0;
            last_dx_reg       <= '0;
            last_dy_reg       <= '0;
            last_btn_reg      <= '0;
        end
        else if (rsp_xfer)
        begin
            last_consumed_reg <= (rsp.event_code == ps2ma_pkg::EvConsumed);
            last_dx_reg       <= rsp.total_dx;
            last_dy_reg       <= rsp.total_dy;
            last_btn_reg      <= rsp.buttons;
        end
    end

    // Only an applied packet moves the totals, and a consume clears them afterwards.
    assign totals_kept = rsp.event_code != ps2ma_pkg::EvApplied
                      && rsp.event_code != ps2ma_pkg::EvConsumed
                      && !last_consumed_reg;
    assign buttons_kept = rsp.event_code != ps2ma_pkg::EvApplied
                       && rsp.event_code != ps2ma_pkg::EvOverflow;

    assign rsp_held     = rsp_valid && rsp_stall;
    assign clear_due    = rsp_valid && last_consumed_reg
                       && rsp.event_code != ps2ma_pkg::EvApplied;
    assign totals_zero  = rsp.total_dx == 16'd0 && rsp.total_dy == 16'd0;
    assign totals_same  = rsp.total_dx == last_dx_reg && rsp.total_dy == last_dy_reg;
    assign buttons_same = rsp.buttons == last_btn_reg;

    `PS2MA_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "stalled response changed")
    `PS2MA_ASSERT_SAME(a_clear_after_consume, clear_due, totals_zero, "totals not cleared")
    `PS2MA_ASSERT_SAME(a_totals_kept, rsp_valid && totals_kept, totals_same, "totals moved")
    `PS2MA_ASSERT_SAME(a_buttons_kept, rsp_valid && buttons_kept, buttons_same, "buttons moved")

endmodule

bind ps2_mouse_packet_accumulator ps2ma_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
